>>> design/assert_macros.svh
// Assertion macros shared by the checker files of the downsampler.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/bxds_pkg.sv
// Shared widths, register indexes and controller/datapath interface types
// for the box average downsampler. No dependencies.
package bxds_pkg;

  // Field and register widths.
  localparam int PIX_W       = 8;
  localparam int DIM_W       = 13;
  localparam int SCALE_REG_W = 5;
  localparam int IDX_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DATA_W  = PIX_W + 2 * IDX_W;

  // Height saturates here whatever the buffer size.
  localparam int HEIGHT_LIMIT = 4096;

  // Default buffer dimensions.
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_SCALE = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // input transaction this cycle
    logic rd_issue;   // issue one row store read of the block
    logic div_start;  // start dividing the block sum
    logic out_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic block_end;  // current pixel closes a block
    logic rd_last;    // this read is the last of the block
    logic div_done;   // quotient is ready
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

>>> design/bxds_div.sv
// Restoring divider producing one quotient bit per cycle.
// Depends on nothing; used by the downsampler datapath.
module bxds_div #(
  parameter int DEND_W = 16,
  parameter int DSOR_W = 9,
  parameter int Q_W    = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DEND_W-1:0] dividend,
  input  logic [DSOR_W-1:0] divisor,
  output logic              done,
  output logic [Q_W-1:0]    quotient
);

  localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DEND_W-1:0] rem;
  logic [DEND_W-1:0] dsh;
  logic              fits;

  // The quotient is known to fit in Q_W bits, so the divisor starts shifted
  // up by Q_W-1 places and walks down one place a cycle.
  assign fits = (rem >= dsh);

  // Control: busy flag, step counter and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(Q_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - STEP_W'(1);
        end
      end
    end
  end

  // Remainder, shifted divisor and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= DEND_W'(divisor) << (Q_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[Q_W-2:0], fits};
    end
  end

endmodule

>>> design/bxds_ctrl.sv
// Controller state machine of the downsampler: sequences pixel intake,
// block reads, division and result hand-over. Depends on bxds_pkg.
module bxds_ctrl
  import bxds_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output cmd_t    cmd,
  input  status_t st
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_DIVST = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_HOLD  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.accept    = s_tvalid && s_tready;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && st.block_end) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.rd_issue = 1'b1;
        if (st.rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      // The last read word is added to the sum in this cycle.
      ST_DRAIN: begin
        state_next = ST_DIVST;
      end
      ST_DIVST: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (st.div_done) begin
          if (st.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/bxds_datapath.sv
// Datapath of the downsampler: configuration registers, raster counters,
// row store, block summation, divider and result register.
// Depends on bxds_pkg and bxds_div.
module bxds_datapath
  import bxds_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic [PIX_W-1:0]     pixel,
  input  logic                 m_tready,
  input  cmd_t                 cmd,
  output status_t              st,
  output logic                 out_valid,
  output logic [PIX_W-1:0]     avg_value,
  output logic [IDX_W-1:0]     out_col,
  output logic [IDX_W-1:0]     out_row,
  output logic                 frame_end
);

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_SCALE;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SC_W      = $clog2(MAX_SCALE + 1);
  localparam int PH_W      = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SQ_W      = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int SUM_W     = SQ_W + PIX_W;

  // Configuration registers.
  logic [DIM_W-1:0]       img_width;
  logic [DIM_W-1:0]       img_height;
  logic [SCALE_REG_W-1:0] scale_factor;
  logic                   cfg_hit;

  // Effective geometry.
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [DIM_W-1:0] s_full;
  logic [SC_W-1:0]  s;
  logic [PH_W-1:0]  s_m1;
  logic [2*SC_W-1:0] s_sq;

  // Raster position.
  logic [DIM_W-1:0]  col;
  logic [DIM_W-1:0]  row;
  logic [PH_W-1:0]   col_ph;
  logic [PH_W-1:0]   row_ph;
  logic [IDX_W-1:0]  col_blk;
  logic [IDX_W-1:0]  row_blk;
  logic [ADDR_W-1:0] wbase;
  logic              last_col;
  logic              last_row;
  logic              col_end;
  logic              row_end;

  // Block read and summation.
  logic [PIX_W-1:0]  mem [MEM_DEPTH];
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] rbase;
  logic [PH_W-1:0]   dx;
  logic [PH_W-1:0]   dy;
  logic [PIX_W-1:0]  rd_data;
  logic              rd_valid;
  logic [DIM_W-1:0]  x0;
  logic [IDX_W-1:0]  bx;
  logic [IDX_W-1:0]  by;
  logic              fe;
  logic [SQ_W-1:0]   sq;
  logic [SUM_W-1:0]  acc;

  // Division.
  logic             div_done;
  logic [PIX_W-1:0] quotient;

  // Any write to a listed register restarts the frame.
  assign cfg_hit = cfg_we && ((cfg_index == REG_IMG_WIDTH) ||
                              (cfg_index == REG_IMG_HEIGHT) ||
                              (cfg_index == REG_SCALE_FACTOR));

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width    <= DIM_W'(1);
      img_height   <= DIM_W'(1);
      scale_factor <= SCALE_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMG_WIDTH:    img_width    <= cfg_data;
        REG_IMG_HEIGHT:   img_height   <= cfg_data;
        REG_SCALE_FACTOR: scale_factor <= cfg_data[SCALE_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Width and height are clamped to the supported range, and the block side
  // to the buffer depth and to the image itself.
  always_comb begin
    logic [DIM_W-1:0] sr;
    if (img_width == '0) begin
      w = DIM_W'(1);
    end else if (32'(img_width) > MAX_WIDTH) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = img_width;
    end
    if (img_height == '0) begin
      h = DIM_W'(1);
    end else if (32'(img_height) > HEIGHT_LIMIT) begin
      h = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h = img_height;
    end
    if (scale_factor == '0) begin
      sr = DIM_W'(1);
    end else if (32'(scale_factor) > MAX_SCALE) begin
      sr = DIM_W'(MAX_SCALE);
    end else begin
      sr = DIM_W'(scale_factor);
    end
    if (sr > w) begin
      sr = w;
    end
    if (sr > h) begin
      sr = h;
    end
    s_full = sr;
  end

  assign s    = SC_W'(s_full);
  assign s_m1 = PH_W'(s_full - DIM_W'(1));
  assign s_sq = {SC_W'(0), s} * {SC_W'(0), s};

  // A block closes on every S-th position and on the last one of a line;
  // the last block is pulled back so that it ends at the image edge.
  assign last_col = (col == w - DIM_W'(1));
  assign last_row = (row == h - DIM_W'(1));
  assign col_end  = last_col || (col_ph == s_m1);
  assign row_end  = last_row || (row_ph == s_m1);

  // Raster counters, phase within a block and block indexes.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col     <= '0;
      row     <= '0;
      col_ph  <= '0;
      row_ph  <= '0;
      col_blk <= '0;
      row_blk <= '0;
      wbase   <= '0;
    end else if (cmd.accept) begin
      if (last_col) begin
        col     <= '0;
        col_ph  <= '0;
        col_blk <= '0;
        if (last_row) begin
          row     <= '0;
          row_ph  <= '0;
          row_blk <= '0;
          wbase   <= '0;
        end else begin
          row <= row + DIM_W'(1);
          if (row_ph == s_m1) begin
            row_ph  <= '0;
            row_blk <= row_blk + IDX_W'(1);
            wbase   <= '0;
          end else begin
            row_ph <= row_ph + PH_W'(1);
            wbase  <= wbase + ADDR_W'(MAX_WIDTH);
          end
        end
      end else begin
        col <= col + DIM_W'(1);
        if (col_ph == s_m1) begin
          col_ph  <= '0;
          col_blk <= col_blk + IDX_W'(1);
        end else begin
          col_ph <= col_ph + PH_W'(1);
        end
      end
    end
  end

  // Row store: line slot times the buffer width plus the column.
  assign waddr = wbase + ADDR_W'(col);
  assign raddr = rbase + ADDR_W'(x0) + ADDR_W'(dx);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[waddr] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= mem[raddr];
    end
  end

  // Block set-up on the pixel that closes it, then the read walk over every
  // line slot and every column of the block.
  always_ff @(posedge clk) begin
    if (cmd.accept && st.block_end) begin
      x0    <= col + DIM_W'(1) - DIM_W'(s);
      bx    <= col_blk;
      by    <= row_blk;
      fe    <= last_col && last_row;
      sq    <= SQ_W'(s_sq);
      rbase <= '0;
      dx    <= '0;
      dy    <= '0;
    end else if (cmd.rd_issue) begin
      if (dx == s_m1) begin
        dx    <= '0;
        dy    <= dy + PH_W'(1);
        rbase <= rbase + ADDR_W'(MAX_WIDTH);
      end else begin
        dx <= dx + PH_W'(1);
      end
    end
  end

  // Read data is registered and arrives in the cycle after its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && st.block_end) begin
      acc <= '0;
    end else if (rd_valid) begin
      acc <= acc + SUM_W'(rd_data);
    end
  end

  // Mean of the block: sum divided by the block area.
  bxds_div #(
    .DEND_W (SUM_W),
    .DSOR_W (SQ_W),
    .Q_W    (PIX_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc),
    .divisor  (sq),
    .done     (div_done),
    .quotient (quotient)
  );

  // Result register; it frees up in the cycle its transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      avg_value <= quotient;
      out_col   <= bx;
      out_row   <= by;
      frame_end <= fe;
    end
  end

  // Status back to the controller.
  always_comb begin
    st           = '0;
    st.block_end = col_end && row_end;
    st.rd_last   = (dx == s_m1) && (dy == s_m1);
    st.div_done  = div_done;
    st.out_free  = !out_valid || m_tready;
  end

endmodule

>>> design/box_average_downsampler.sv
// Top level of the box average downsampler: joins controller and datapath
// and packs the stream payloads. Depends on bxds_pkg, bxds_ctrl and
// bxds_datapath.

// Pixels arrive in raster order, one per input transaction, and every
// S by S block yields one output transaction carrying its truncated mean,
// its block column and row, and tlast on the final block of the frame.
// A pixel that does not close a block is taken without holding the input
// off. A pixel that closes a block holds the input off while the block is
// read back from the row store through its single read port, one pixel a
// cycle, and the sum is then divided by S*S one quotient bit a cycle. A
// finished result waits in an output register, so a stalled output only
// holds the input off when a further block closes. Configure the
// registers while the block is idle; any write to the width, height or
// scale register restarts the frame at row 0, column 0. The row store
// needs no clearing after reset, so the block is ready as soon as reset
// is released.
module box_average_downsampler
  import bxds_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] avg_value, [19:8] out_col,
                                           // [31:20] out_row
  output logic                  m_tlast    // frame_end
);

  cmd_t             cmd;
  status_t          st;
  logic [PIX_W-1:0] avg_value;
  logic [IDX_W-1:0] out_col;
  logic [IDX_W-1:0] out_row;

  bxds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .st       (st)
  );

  bxds_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (s_tdata),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_tvalid),
    .avg_value (avg_value),
    .out_col   (out_col),
    .out_row   (out_row),
    .frame_end (m_tlast)
  );

  // Output payload, first field in the lowest bits.
  assign m_tdata = {out_row, out_col, avg_value};

endmodule

>>> design/bxds_checker.sv
// Port-level checker for the box average downsampler and its bind.
// Depends on bxds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bxds_checker
  import bxds_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // Reset empties the result register.
  `ASSERT_CLK(a_reset_empties_output, rst |=> !m_tvalid, "result valid after reset")

  // A stalled result keeps its payload.
  `ASSERT_CLKD(a_output_holds,
               m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
               "stalled result changed")

  // A new result is only produced while the input side is held off.
  `ASSERT_CLKD(a_result_while_busy,
               $rose(m_tvalid) |-> !$past(s_tready),
               "result appeared while idle")

  // The input side only closes after a pixel transaction.
  `ASSERT_CLKD(a_busy_after_pixel,
               $fell(s_tready) |-> $past(s_tvalid),
               "ready dropped without a pixel")

endmodule

bind box_average_downsampler bxds_checker u_bxds_checker (.*);

>>> sim/tb_box_average_downsampler.sv
`timescale 1ns / 100ps
// Self-checking testbench for the box average downsampler: streams raster pixels,
// predicts every block mean with a behavioural model and checks each output transaction.
// Depends on bxds_pkg and box_average_downsampler.
module tb_box_average_downsampler;
  import bxds_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_S = DEF_MAX_SCALE;
  // Index that selects no register; a write there must leave the frame alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RAND_ITEMS   = 1450;
  localparam int PHASE_LEN    = 370;
  localparam int DRAIN_CYCLES = MAX_S * MAX_S + 40;
  localparam int CYCLE_LIMIT  = 3000000;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_FULL} fill_t;

  typedef struct packed {
    logic [PIX_W-1:0] avg_value;
    logic [IDX_W-1:0] out_col;
    logic [IDX_W-1:0] out_row;
    logic             frame_end;
  } block_mean_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DIM_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // Behavioural copy of the block: the last rows, the raster position and the registers.
  logic [PIX_W-1:0] pixel_rows [0:MAX_W*MAX_S-1];
  int unsigned cfg_width, cfg_height, cfg_scale;
  int unsigned col_pos, row_pos;

  block_mean_t      mean_q[$];
  logic [PIX_W-1:0] pixel_q[$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  box_average_downsampler u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // Zero is taken as one and anything above the limit saturates.
  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Does position p close a block along an axis of length n? The last block is
  // pulled back so that it ends on the image edge.
  function automatic bit closes_block(input int unsigned p, n, s,
                                      output int unsigned idx, output int unsigned first);
    if (p == n - 1) begin
      idx   = (n + s - 1) / s - 1;
      first = n - s;
      return 1'b1;
    end
    if ((p + 1) % s == 0) begin
      idx   = (p + 1) / s - 1;
      first = p + 1 - s;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Store one accepted pixel and queue the block mean it completes, if any.
  task automatic predict_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w, h, s, c, r, bx, by, x0, y0, sum;
    block_mean_t res;
    w = clamp_dim(cfg_width, MAX_W);
    h = clamp_dim(cfg_height, HEIGHT_LIMIT);
    s = clamp_dim(cfg_scale, MAX_S);
    if (s > w) s = w;
    if (s > h) s = h;
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    pixel_rows[(r % s) * MAX_W + c] = pix;
    if (closes_block(c, w, s, bx, x0) && closes_block(r, h, s, by, y0)) begin
      sum = 0;
      for (int unsigned dy = 0; dy < s; dy++) begin
        for (int unsigned dx = 0; dx < s; dx++) begin
          sum += pixel_rows[((y0 + dy) % s) * MAX_W + x0 + dx];
        end
      end
      res.avg_value = PIX_W'(sum / (s * s));
      res.out_col   = IDX_W'(bx);
      res.out_row   = IDX_W'(by);
      res.frame_end = (bx == (w + s - 1) / s - 1) && (by == (h + s - 1) / s - 1);
      mean_q = {mean_q, res};
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Idling phases follow the number of pixels taken so far.
  function automatic int unsigned idle_phase();
    return (items_taken / PHASE_LEN > 3) ? 3 : items_taken / PHASE_LEN;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (idle_phase())
      1: return 63;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case (idle_phase())
      2: return 63;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  // Pixel driver: holds a transaction until it is taken, idles at random otherwise.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_pixel(s_tdata);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pixel_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each output transaction with the oldest expected mean.
  always @(posedge clk) begin
    block_mean_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.avg_value = m_tdata[PIX_W-1:0];
        got.out_col   = m_tdata[PIX_W+IDX_W-1:PIX_W];
        got.out_row   = m_tdata[PIX_W+2*IDX_W-1:PIX_W+IDX_W];
        got.frame_end = m_tlast;
        if (mean_q.size() == 0) begin
          $error("unexpected output transaction: avg_value %0d out_col %0d out_row %0d",
                 got.avg_value, got.out_col, got.out_row);
          fail_count++;
        end else begin
          want = mean_q.pop_front();
          if (got.avg_value !== want.avg_value) begin
            $error("avg_value mismatch: expected %0d, actual %0d", want.avg_value,
                   got.avg_value);
            fail_count++;
          end
          if (got.out_col !== want.out_col) begin
            $error("out_col mismatch: expected %0d, actual %0d", want.out_col, got.out_col);
            fail_count++;
          end
          if (got.out_row !== want.out_row) begin
            $error("out_row mismatch: expected %0d, actual %0d", want.out_row, got.out_row);
            fail_count++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0d, actual %0d", want.frame_end,
                   got.frame_end);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One register write; the model sees it at the same moment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_IMG_WIDTH: begin
        cfg_width = value;
        col_pos = 0;
        row_pos = 0;
      end
      REG_IMG_HEIGHT: begin
        cfg_height = value;
        col_pos = 0;
        row_pos = 0;
      end
      REG_SCALE_FACTOR: begin
        cfg_scale = value[SCALE_REG_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_results();
    while (!(items_taken == items_queued && mean_q.size() == 0)) @(posedge clk);
  endtask

  // Wait until every pixel is taken and every mean has come, then let a block in flight finish.
  task automatic drain();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int unsigned w, h, input logic [DIM_W-1:0] scale_word);
    drain();
    write_reg(REG_IMG_WIDTH, DIM_W'(w));
    write_reg(REG_IMG_HEIGHT, DIM_W'(h));
    write_reg(REG_SCALE_FACTOR, scale_word);
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] pix);
    pixel_q = {pixel_q, pix};
    items_queued++;
  endtask

  task automatic push_pixels(input int unsigned n, input fill_t fill);
    for (int unsigned i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: push_pixel('0);
        FILL_FULL: push_pixel('1);
        default:   push_pixel(PIX_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Stimulus: a directed part, then random frames under several register settings.
  initial begin
    int unsigned w, h, sc, n, pick, r;
    fill_t fill;
    bit paused_once;
    int unsigned rand_end;
    paused_once = 1'b0;
    for (int i = 0; i < MAX_W * MAX_S; i++) pixel_rows[i] = '0;
    cfg_width  = 1;
    cfg_height = 1;
    cfg_scale  = 1;
    col_pos    = 0;
    row_pos    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: every pixel is its own one-pixel frame.
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h55);
    push_pixel(8'hAA);

    // Zero in every register is taken as one.
    configure(0, 0, '0);
    push_pixel(8'h3C);

    // Scale beyond the image, with an overlapping last block column.
    configure(3, 2, DIM_W'(16));
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h80);

    // Scale saturates and then shrinks to the image; a write to the spare index
    // in mid-frame must not restart the frame.
    configure(2, 2, '1);
    push_pixel(8'h10);
    push_pixel(8'hF0);
    drain();
    write_reg(REG_UNUSED, '1);
    push_pixel(8'h01);
    push_pixel(8'hFE);

    // Width and height above their limits saturate.
    configure(8191, 8191, DIM_W'(1));
    push_pixel(8'h7F);
    push_pixel(8'h80);
    push_pixel(8'hC3);

    // Tallest image, one column wide.
    configure(1, HEIGHT_LIMIT, DIM_W'(MAX_S));
    push_pixel(8'h0F);
    push_pixel(8'hF0);
    push_pixel(8'h99);

    // Random frames, mostly whole frames with a partial one now and then.
    rand_end = items_queued + RAND_ITEMS;
    while (items_queued < rand_end) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // Very wide, one row: every pixel closes a block.
        w  = $urandom_range(0, 1) ? MAX_W : $urandom_range(4000, 8191);
        h  = $urandom_range(0, 1);
        sc = $urandom_range(0, 31);
        n  = $urandom_range(10, 40);
      end else if (pick < 11) begin
        // Very tall and narrow, only the top of the frame.
        w  = $urandom_range(1, 3);
        h  = $urandom_range(0, 1) ? HEIGHT_LIMIT : $urandom_range(4000, 8191);
        sc = $urandom_range(1, 4);
        n  = w * $urandom_range(4, 15);
      end else begin
        w = $urandom_range(1, 20);
        h = $urandom_range(1, 20);
        r = $urandom_range(0, 99);
        if (r < 8) sc = 0;
        else if (r < 16) sc = $urandom_range(17, 31);
        else if (r < 60) sc = $urandom_range(1, (w < h) ? w : h);
        else sc = $urandom_range(1, MAX_S);
        n = w * h * $urandom_range(1, 2);
        if ($urandom_range(0, 4) == 0) n += $urandom_range(1, w * h);
      end
      // The last frame stops where the pixel budget runs out.
      if (n > rand_end - items_queued) n = rand_end - items_queued;
      configure(w, h, {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, 5'(sc)});
      r = $urandom_range(0, 19);
      fill = (r == 0) ? FILL_ZERO : (r < 3) ? FILL_FULL : FILL_RANDOM;
      push_pixels(n / 2, fill);
      // Once, the sender stops in mid-frame until every expected mean has come.
      if (!paused_once) begin
        wait_results();
        paused_once = 1'b1;
      end
      push_pixels(n - n / 2, fill);
    end

    drain();
    if (fail_count == 0 && mean_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
